>>> rtl/postfix_stack_evaluator_defines.svh
// Assertion macros for the postfix stack evaluator checker
`ifndef POSTFIX_STACK_EVALUATOR_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_DEFINES_SVH
// implication checked on every clock edge outside reset
`define PSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define PSE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> rtl/pse_pkg.sv
// Package: payload types and codes for the postfix stack evaluator
package pse_pkg;
    localparam logic [2:0] CMD_PUSH_LIT = 3'd0;
    localparam logic [2:0] CMD_PUSH_VAR = 3'd1;
    localparam logic [2:0] CMD_APPLY    = 3'd2;
    localparam logic [2:0] CMD_FINISH   = 3'd3;
    localparam logic [2:0] CMD_WRITE    = 3'd4;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;
    localparam logic [2:0] OP_NEG = 3'd5;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_UNDER = 2'd1;
    localparam logic [1:0] ERR_OVER  = 2'd2;

    localparam int NUM_VARS = 26;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] literal;
        logic [4:0]         var_index;
        logic [2:0]         op_code;
    } pse_in_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic [1:0]         error;
    } pse_out_t;
endpackage

>>> rtl/postfix_stack_evaluator.sv
// Top level: postfix token evaluator with value stack and shared ALU
//  channel | signals                 | payload
//  in      | in_valid / in_stall     | pse_in_t  (cmd, literal, var_index, op_code)
//  out     | out_valid / out_stall   | pse_out_t (result, error)
// Push literal/variable: push state. Write variable: done in idle. Operators pop B then A, execute, push.
// Negate pops only B. Divide: one quotient bit a cycle in the divide state (zero result if by zero).
// Power: one square or multiply per cycle in the multiplier shared with multiply. Finish pops B.
// Reset clears pointer, error and variables; stack contents are never read before written.
// A result waits in the output register; a new word is taken only once it has gone.
module postfix_stack_evaluator
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  pse_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output pse_out_t out_data
);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PW = $clog2(STACK_DEPTH + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_POPB  = 4'd1;
    localparam logic [3:0] S_RDB   = 4'd2;
    localparam logic [3:0] S_POPA  = 4'd3;
    localparam logic [3:0] S_RDA   = 4'd4;
    localparam logic [3:0] S_EXEC  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_POW   = 4'd7;
    localparam logic [3:0] S_PUSH  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;
    localparam logic [3:0] S_MUL   = 4'd10;

    logic [3:0]    state_reg, state_next;
    pse_in_t       tok_reg, tok_next;
    logic [PW-1:0] sp_reg, sp_next;
    logic [1:0]    err_reg, err_next;
    logic [31:0]   a_reg, a_next, b_reg, b_next;
    logic [31:0]   acc_reg, acc_next;
    logic [31:0]   rem_reg, rem_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic          fin_reg, fin_next;
    logic          bok_reg, bok_next, aok_reg, aok_next;
    logic          out_valid_reg, out_valid_next;
    pse_out_t      out_reg, out_next;
    logic [31:0]   vars_reg [NUM_VARS];

    logic [31:0]   stack_mem [STACK_DEPTH];
    logic [31:0]   rd_data_reg;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [31:0]   wr_data;

    logic [31:0]   mul_x, mul_y, mul_p;
    logic [32:0]   trial;
    logic          vwr_en;

    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign mul_p     = mul_x * mul_y;
    assign trial     = {rem_reg, acc_reg[31]} - {1'b0, b_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_VARS; i++)
            begin
                vars_reg[i] <= '0;
            end
        end
        else if (vwr_en)
        begin
            vars_reg[in_data.var_index] <= in_data.literal;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        tok_next       = tok_reg;
        sp_next        = sp_reg;
        err_next       = err_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        fin_next       = fin_reg;
        bok_next       = bok_reg;
        aok_next       = aok_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        rd_en          = 1'b0;
        rd_addr        = sp_reg[AW-1:0] - AW'(1);
        wr_en          = 1'b0;
        wr_addr        = sp_reg[AW-1:0];
        wr_data        = acc_reg;
        mul_x          = a_reg;
        mul_y          = b_reg;
        vwr_en         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    tok_next = in_data;
                    fin_next = 1'b0;
                    case (in_data.cmd)
                        CMD_PUSH_LIT:
                        begin
                            acc_next   = in_data.literal;
                            state_next = S_PUSH;
                        end
                        CMD_PUSH_VAR:
                        begin
                            acc_next   = (in_data.var_index < 5'(NUM_VARS)) ?
                                         vars_reg[in_data.var_index] : '0;
                            state_next = S_PUSH;
                        end
                        CMD_APPLY:
                        begin
                            state_next = S_POPB;
                        end
                        CMD_FINISH:
                        begin
                            fin_next   = 1'b1;
                            state_next = S_POPB;
                        end
                        CMD_WRITE:
                        begin
                            vwr_en     = in_data.var_index < 5'(NUM_VARS);
                            state_next = S_IDLE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_POPB:
            begin
                if (sp_reg == '0)
                begin
                    bok_next = 1'b0;
                    if (err_reg == ERR_NONE)
                    begin
                        err_next = ERR_UNDER;
                    end
                end
                else
                begin
                    bok_next = 1'b1;
                    rd_en    = 1'b1;
                    sp_next  = sp_reg - PW'(1);
                end
                state_next = S_RDB;
            end
            S_RDB:
            begin
                b_next = bok_reg ? rd_data_reg : '0;
                if (fin_reg)
                begin
                    state_next = S_FIN;
                end
                else if (tok_reg.op_code == OP_NEG)
                begin
                    a_next     = '0;
                    b_next     = bok_reg ? rd_data_reg : '0;
                    tok_next.op_code = OP_SUB;
                    state_next = S_EXEC;
                end
                else
                begin
                    state_next = S_POPA;
                end
            end
            S_POPA:
            begin
                if (sp_reg == '0)
                begin
                    aok_next = 1'b0;
                    if (err_reg == ERR_NONE)
                    begin
                        err_next = ERR_UNDER;
                    end
                end
                else
                begin
                    aok_next = 1'b1;
                    rd_en    = 1'b1;
                    sp_next  = sp_reg - PW'(1);
                end
                state_next = S_RDA;
            end
            S_RDA:
            begin
                a_next     = aok_reg ? rd_data_reg : '0;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_PUSH;
                case (tok_reg.op_code)
                    OP_ADD: acc_next = a_reg + b_reg;
                    OP_SUB: acc_next = a_reg - b_reg;
                    OP_MUL: state_next = S_MUL;
                    OP_DIV:
                    begin
                        if (b_reg == '0)
                        begin
                            acc_next = '0;
                        end
                        else
                        begin
                            acc_next   = a_reg[31] ? -a_reg : a_reg;
                            b_next     = b_reg[31] ? -b_reg : b_reg;
                            rem_next   = '0;
                            cnt_next   = 6'd32;
                            tok_next.literal = {(a_reg[31] != b_reg[31]), 31'd0};
                            state_next = S_DIV;
                        end
                    end
                    OP_POW:
                    begin
                        acc_next = 32'd1;
                        if (!b_reg[31])
                        begin
                            state_next = S_POW;
                        end
                    end
                    default: acc_next = '0;
                endcase
            end
            S_MUL:
            begin
                acc_next   = mul_p;
                state_next = S_PUSH;
            end
            S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    acc_next   = tok_reg.literal[31] ? -acc_reg : acc_reg;
                    state_next = S_PUSH;
                end
                else
                begin
                    if (!trial[32])
                    begin
                        rem_next = trial[31:0];
                        acc_next = {acc_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = {rem_reg[30:0], acc_reg[31]};
                        acc_next = {acc_reg[30:0], 1'b0};
                    end
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            S_POW:
            begin
                if (b_reg == '0)
                begin
                    state_next = S_PUSH;
                end
                else if (b_reg[0])
                begin
                    mul_x    = acc_reg;
                    mul_y    = a_reg;
                    acc_next = mul_p;
                    b_next   = b_reg - 32'd1;
                end
                else
                begin
                    mul_x  = a_reg;
                    mul_y  = a_reg;
                    a_next = mul_p;
                    b_next = {1'b0, b_reg[31:1]};
                end
            end
            S_PUSH:
            begin
                if (sp_reg >= PW'(STACK_DEPTH))
                begin
                    if (err_reg == ERR_NONE)
                    begin
                        err_next = ERR_OVER;
                    end
                end
                else
                begin
                    wr_en   = 1'b1;
                    sp_next = sp_reg + PW'(1);
                end
                state_next = S_IDLE;
            end
            S_FIN:
            begin
                out_next.result = b_reg;
                out_next.error  = err_reg;
                out_valid_next  = 1'b1;
                sp_next         = '0;
                err_next        = ERR_NONE;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            fin_reg       <= 1'b0;
            bok_reg       <= 1'b0;
            aok_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            fin_reg       <= fin_next;
            bok_reg       <= bok_next;
            aok_reg       <= aok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        out_reg <= out_next;
    end
endmodule

>>> rtl/pse_checker.sv
// Port-level checker for the postfix stack evaluator, bound to the top level
`include "postfix_stack_evaluator_defines.svh"
module pse_checker
    import pse_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input pse_in_t  in_data,
    input logic     out_valid,
    input logic     out_stall,
    input pse_out_t out_data
);
    `PSE_ASSERT_IMP(a_err_code, clk, rst_n, out_valid, out_data.error != 2'd3)
    `PSE_ASSERT_IMP(a_busy_out, clk, rst_n, out_valid, in_stall)
    `PSE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
    `PSE_ASSERT_NXT(a_take_busy, clk, rst_n, in_valid && !in_stall && in_data.cmd != CMD_WRITE
        && in_data.cmd <= CMD_WRITE, in_stall)
endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

>>> tb/sv/testbench.sv
// Testbench for the postfix stack evaluator: queue-fed driver, monitor, scoreboard
module testbench;
    import pse_pkg::*;

    localparam int DEPTH     = 64;
    localparam int MAX_CYC   = 3000000;
    localparam int DRAIN_CYC = 200;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    pse_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    pse_out_t out_data;

    postfix_stack_evaluator #(.STACK_DEPTH(DEPTH)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // predictor state
    logic [31:0] stack_mem [DEPTH];
    int unsigned stack_ptr;
    logic [31:0] var_mem [NUM_VARS];
    logic [1:0]  err_hold;

    pse_in_t  word_queue [$];
    pse_out_t finish_queue [$];
    int       send_idle_pct;
    int       recv_stall_pct;
    int       hold_cycles;
    int       fails;
    int       cycles;
    bit       stim_done;

    function automatic void raise_err(logic [1:0] e);
        if (err_hold == ERR_NONE)
            err_hold = e;
    endfunction

    function automatic void push_value(logic [31:0] v);
        if (stack_ptr >= DEPTH)
            raise_err(ERR_OVER);
        else
        begin
            stack_mem[stack_ptr] = v;
            stack_ptr++;
        end
    endfunction

    function automatic logic [31:0] pop_value();
        if (stack_ptr == 0)
        begin
            raise_err(ERR_UNDER);
            return 32'd0;
        end
        stack_ptr--;
        return stack_mem[stack_ptr];
    endfunction

    function automatic logic [31:0] signed_quot(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        if (b == 0)
            return 32'd0;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic logic [31:0] wrap_power(logic [31:0] base, logic [31:0] ex);
        logic [31:0] acc;
        acc = 32'd1;
        if (ex[31])
            return 32'd1;
        while (ex != 0)
        begin
            if (ex[0])
            begin
                acc = acc * base;
                ex = ex - 1;
            end
            else
            begin
                base = base * base;
                ex = ex >> 1;
            end
        end
        return acc;
    endfunction

    function automatic void predict_word(pse_in_t w);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        pse_out_t    o;
        case (w.cmd)
            CMD_PUSH_LIT: push_value(w.literal);
            CMD_PUSH_VAR: push_value(w.var_index < NUM_VARS ? var_mem[w.var_index] : 32'd0);
            CMD_APPLY:
                if (w.op_code == OP_NEG)
                begin
                    a = pop_value();
                    push_value(-a);
                end
                else
                begin
                    b = pop_value();
                    a = pop_value();
                    case (w.op_code)
                        OP_ADD:  r = a + b;
                        OP_SUB:  r = a - b;
                        OP_MUL:  r = a * b;
                        OP_DIV:  r = signed_quot(a, b);
                        OP_POW:  r = wrap_power(a, b);
                        default: r = 32'd0;
                    endcase
                    push_value(r);
                end
            CMD_FINISH:
            begin
                o.result = pop_value();
                o.error = err_hold;
                finish_queue.push_back(o);
                stack_ptr = 0;
                err_hold = ERR_NONE;
            end
            CMD_WRITE:
                if (w.var_index < NUM_VARS)
                    var_mem[w.var_index] = w.literal;
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 9);
            1:       return -$urandom_range(0, 9);
            2:       return 32'h8000_0000 ^ $urandom_range(0, 1);
            3:       return 32'h7fff_ffff - $urandom_range(0, 1);
            default: return $urandom;
        endcase
    endfunction

    function automatic pse_in_t make_word(logic [2:0] c, logic [31:0] v,
                                          logic [4:0] x, logic [2:0] o);
        pse_in_t w;
        w.cmd = c;
        w.literal = v;
        w.var_index = x;
        w.op_code = o;
        return w;
    endfunction

    function automatic void add_word(logic [2:0] c, logic [31:0] v,
                                     logic [4:0] x, logic [2:0] o);
        word_queue.push_back(make_word(c, v, x, o));
    endfunction

    // one well-formed expression, some broken, ends with finish
    function automatic void add_expr();
        int n;
        int depth;
        int k;
        n = $urandom_range(1, 8);
        depth = 0;
        for (k = 0; k < n || depth > 1; k++)
        begin
            if (depth >= 2 && (k >= n || $urandom_range(0, 2) == 0))
            begin
                add_word(CMD_APPLY, $urandom, $urandom, $urandom_range(0, 4));
                depth--;
            end
            else if (depth >= 1 && $urandom_range(0, 7) == 0)
                add_word(CMD_APPLY, $urandom, $urandom, OP_NEG);
            else if ($urandom_range(0, 3) == 0)
            begin
                add_word(CMD_PUSH_VAR, $urandom, $urandom_range(0, 31), $urandom);
                depth++;
            end
            else if ($urandom_range(0, 9) == 0)
                add_word(CMD_WRITE, rand_value(), $urandom_range(0, 31), $urandom);
            else
            begin
                add_word(CMD_PUSH_LIT, rand_value(), $urandom, $urandom);
                depth++;
            end
            if (k > 40)
                break;
        end
        if ($urandom_range(0, 7) == 0)
            add_word($urandom_range(0, 7), rand_value(), $urandom, $urandom);
        add_word(CMD_FINISH, $urandom, $urandom, $urandom);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                predict_word(in_data);
            if (word_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data <= word_queue.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (finish_queue.size() == 0)
            begin
                $display("%0t: unexpected word result=%h error=%0d",
                         $time, out_data.result, out_data.error);
                fails++;
            end
            else
            begin
                if (out_data.result !== finish_queue[0].result)
                begin
                    $display("%0t: result expected %h actual %h",
                             $time, finish_queue[0].result, out_data.result);
                    fails++;
                end
                if (out_data.error !== finish_queue[0].error)
                begin
                    $display("%0t: error expected %0d actual %0d",
                             $time, finish_queue[0].error, out_data.error);
                    fails++;
                end
                void'(finish_queue.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYC)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic run_phase(int idle_pct, int stall_pct, int exprs);
        int k;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (k = 0; k < exprs; k++)
            add_expr();
        while (word_queue.size() > 0 || in_valid)
            @(posedge clk);
    endtask

    initial
    begin
        int k;
        fails = 0;
        cycles = 0;
        hold_cycles = 0;
        stim_done = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        stack_ptr = 0;
        err_hold = ERR_NONE;
        for (k = 0; k < NUM_VARS; k++)
            var_mem[k] = 32'd0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every operator, error cases
        add_word(CMD_FINISH, 0, 0, 0);
        add_word(CMD_PUSH_VAR, 0, 5'd31, 0);
        add_word(CMD_WRITE, 32'h8000_0000, 5'd0, 0);
        add_word(CMD_WRITE, 32'h7fff_ffff, 5'd25, 0);
        add_word(CMD_WRITE, 32'h1234_5678, 5'd31, 0);
        add_word(CMD_PUSH_VAR, 0, 5'd0, 0);
        add_word(CMD_PUSH_LIT, 32'hffff_ffff, 0, 0);
        add_word(CMD_APPLY, 0, 0, OP_DIV);
        add_word(CMD_PUSH_LIT, 7, 0, 0);
        add_word(CMD_PUSH_LIT, 0, 0, 0);
        add_word(CMD_APPLY, 0, 0, OP_DIV);
        add_word(CMD_APPLY, 0, 0, OP_ADD);
        add_word(CMD_PUSH_VAR, 0, 5'd25, 0);
        add_word(CMD_APPLY, 0, 0, OP_SUB);
        add_word(CMD_PUSH_LIT, 3, 0, 0);
        add_word(CMD_APPLY, 0, 0, OP_MUL);
        add_word(CMD_PUSH_LIT, 3, 0, 0);
        add_word(CMD_PUSH_LIT, 32'h7fff_ffff, 0, 0);
        add_word(CMD_APPLY, 0, 0, OP_POW);
        add_word(CMD_PUSH_LIT, -5, 0, 0);
        add_word(CMD_APPLY, 0, 0, OP_POW);
        add_word(CMD_APPLY, 0, 0, OP_NEG);
        add_word(CMD_APPLY, 0, 0, 3'd6);
        add_word(CMD_APPLY, 0, 0, 3'd7);
        add_word(3'd5, 0, 0, 0);
        add_word(3'd7, 32'hffff_ffff, 5'h1f, 3'd7);
        add_word(CMD_FINISH, 0, 0, 0);
        for (k = 0; k < DEPTH + 2; k++)
            add_word(CMD_PUSH_LIT, $urandom, 0, 0);
        add_word(CMD_FINISH, 0, 0, 0);
        add_word(CMD_APPLY, 0, 0, OP_NEG);
        add_word(CMD_PUSH_LIT, 1, 0, 0);
        add_word(CMD_FINISH, 0, 0, 0);
        run_phase(0, 0, 0);

        run_phase(0, 0, 20);
        // long receiver hold while words keep coming
        hold_cycles = 400;
        run_phase(0, 0, 10);
        run_phase(83, 0, 25);
        run_phase(0, 83, 25);
        run_phase(32, 32, 25);
        run_phase(0, 0, 15);

        while (finish_queue.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl
rtl/pse_pkg.sv
rtl/postfix_stack_evaluator.sv
rtl/pse_checker.sv
tb/sv/testbench.sv
